// ----- hdl/msps_pkg.sv -----
// ----------------------------------------------------------------------------
// msps_pkg
// shared constants and codes of the multiplexed servo pulse sequencer
// ----------------------------------------------------------------------------
package msps_pkg;

    localparam int CHANNELS_DEF = 8;

    localparam int CMD_W  = 2;
    localparam int CHAN_W = 3;
    localparam int US_W   = 15;
    localparam int PIN_W  = 8;
    localparam int TICK_W = 16;
    localparam int PHASE_W = 8;

    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ATTACH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET    = 2'd2;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] ADDR_DEFAULT_SLOT = 3'd0;

    localparam logic [TICK_W-1:0] DEFAULT_SLOT_RESET = 16'd4000;

endpackage

// ----- hdl/msps_ifs.sv -----
// ----------------------------------------------------------------------------
// msps interfaces
// valid/ready channels for command items and result items
// ----------------------------------------------------------------------------
interface msps_in_if
    import msps_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [CHAN_W-1:0] channel;
    logic [US_W-1:0]   duration_us;

    modport source (output valid, cmd, channel, duration_us, input ready);
    modport sink   (input valid, cmd, channel, duration_us, output ready);
endinterface

interface msps_out_if
    import msps_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [PIN_W-1:0]  pin_levels;
    logic [CHAN_W-1:0] current_channel;
    logic              accepted;
    logic [CHAN_W-1:0] assigned_channel;

    modport source (output valid, pin_levels, current_channel, accepted, assigned_channel,
                    input ready);
    modport sink   (input valid, pin_levels, current_channel, accepted, assigned_channel,
                    output ready);
endinterface

// ----- hdl/msps_ram.sv -----
// ----------------------------------------------------------------------------
// msps_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module msps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/multiplexed_servo_pulse_sequencer.sv -----
// ----------------------------------------------------------------------------
// multiplexed_servo_pulse_sequencer
// results are registered on transfer; one item per cycle unless output stalls
// the durations ram is read one slot ahead each cycle, with a write bypass, so
// a compare can load the next slot at once
// reset (synchronous, active low): timer stopped, all pins low, no channel
// attached, default slot length 4000 ticks; ram contents are written on attach
// ----------------------------------------------------------------------------
module multiplexed_servo_pulse_sequencer
    import msps_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    msps_in_if.sink            i_item,
    msps_out_if.source         o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW = $clog2(CHANNELS + 1);

    // control state
    logic                r_running, n_running;
    logic [AW-1:0]       r_slot, n_slot;
    logic [TICK_W-1:0]   r_ticks, n_ticks;
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [PHASE_W-1:0]  r_cval, n_cval;
    logic                r_armed, n_armed;
    logic                r_pend, n_pend;
    logic [CHANNELS-1:0] r_levels, n_levels;
    logic [CHANNELS-1:0] r_attached, n_attached;
    logic [CW-1:0]       r_count, n_count;
    logic [TICK_W-1:0]   r_default;

    // output register
    logic                r_out_valid;
    logic [CHANNELS-1:0] r_out_levels;
    logic [AW-1:0]       r_out_slot;
    logic                r_out_acc;
    logic [AW-1:0]       r_out_asg;

    // ram access
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [TICK_W-1:0]   wr_data;
    logic [AW-1:0]       rd_addr;
    logic [TICK_W-1:0]   rd_data;
    logic                r_fwd_hit;
    logic [TICK_W-1:0]   r_fwd_data;
    logic [TICK_W-1:0]   next_ticks;

    logic                in_fire;
    logic                cfg_wr;
    logic                acc;
    logic [AW-1:0]       asg;
    logic [AW-1:0]       slot_next;
    logic [TICK_W-1:0]   load_ticks;
    logic [TICK_W-1:0]   us_ticks;

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign in_fire      = i_item.valid && i_item.ready;
    assign us_ticks     = {i_item.duration_us, 1'b0};

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr == ADDR_DEFAULT_SLOT) ? APB_DW'(r_default) : '0;

    msps_ram #(
        .WIDTH (TICK_W),
        .DEPTH (CHANNELS)
    ) u_ticks_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // ram output holds the entry of the slot after the current one
    assign next_ticks = r_fwd_hit ? r_fwd_data : rd_data;
    assign slot_next  = (r_slot == AW'(CHANNELS - 1)) ? '0 : r_slot + AW'(1);
    assign load_ticks = r_attached[slot_next] ? next_ticks : r_default;
    assign rd_addr    = (n_slot == AW'(CHANNELS - 1)) ? '0 : n_slot + AW'(1);

    always_comb begin
        n_running  = r_running;
        n_slot     = r_slot;
        n_ticks    = r_ticks;
        n_phase    = r_phase;
        n_cval     = r_cval;
        n_armed    = r_armed;
        n_pend     = r_pend;
        n_levels   = r_levels;
        n_attached = r_attached;
        n_count    = r_count;
        wr_en      = 1'b0;
        wr_addr    = r_count[AW-1:0];
        wr_data    = us_ticks;
        acc        = 1'b0;
        asg        = '0;
        if (in_fire) begin
            unique case (i_item.cmd)
                CMD_TICK: begin
                    if (r_running) begin
                        n_phase = r_phase + PHASE_W'(1);
                        // compare before wrap
                        if (r_armed && n_phase == r_cval) begin
                            if (r_attached[r_slot]) begin
                                n_levels[r_slot] = 1'b0;
                            end
                            n_armed = 1'b0;
                            n_slot  = slot_next;
                            n_ticks = load_ticks;
                            n_cval  = load_ticks[PHASE_W-1:0];
                        end
                        if (n_phase == '0) begin
                            if (n_pend) begin
                                if (r_attached[n_slot]) begin
                                    n_levels[n_slot] = 1'b1;
                                end
                                n_pend = 1'b0;
                            end
                            if (|n_ticks[TICK_W-1:PHASE_W]) begin
                                n_ticks = n_ticks - TICK_W'(256);
                            end else begin
                                n_armed = 1'b1;
                                n_ticks = '0;
                                n_pend  = 1'b1;
                            end
                        end
                    end
                end
                CMD_ATTACH: begin
                    if (r_count < CW'(CHANNELS) && i_item.duration_us != '0) begin
                        n_count = r_count + CW'(1);
                        n_attached[r_count[AW-1:0]] = 1'b1;
                        wr_en = 1'b1;
                        acc   = 1'b1;
                        asg   = r_count[AW-1:0];
                        if (!r_running) begin
                            n_slot    = '0;
                            n_ticks   = us_ticks;
                            n_cval    = us_ticks[PHASE_W-1:0];
                            n_armed   = 1'b0;
                            n_phase   = '0;
                            n_running = 1'b1;
                        end
                    end
                end
                CMD_SET: begin
                    if ({29'd0, i_item.channel} < 32'(CHANNELS)) begin
                        wr_en   = 1'b1;
                        wr_addr = i_item.channel[AW-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= 1'b0;
            r_slot      <= '0;
            r_ticks     <= '0;
            r_phase     <= '0;
            r_cval      <= '0;
            r_armed     <= 1'b0;
            r_pend      <= 1'b0;
            r_levels    <= '0;
            r_attached  <= '0;
            r_count     <= '0;
            r_default   <= DEFAULT_SLOT_RESET;
            r_out_valid <= 1'b0;
            r_fwd_hit   <= 1'b0;
        end else begin
            r_running  <= n_running;
            r_slot     <= n_slot;
            r_ticks    <= n_ticks;
            r_phase    <= n_phase;
            r_cval     <= n_cval;
            r_armed    <= n_armed;
            r_pend     <= n_pend;
            r_levels   <= n_levels;
            r_attached <= n_attached;
            r_count    <= n_count;
            r_fwd_hit  <= wr_en && (wr_addr == rd_addr);
            if (cfg_wr && paddr == ADDR_DEFAULT_SLOT) begin
                r_default <= pwdata[TICK_W-1:0];
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= wr_data;
        if (in_fire) begin
            r_out_levels <= n_levels;
            r_out_slot   <= n_slot;
            r_out_acc    <= acc;
            r_out_asg    <= asg;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.pin_levels       = PIN_W'(r_out_levels);
    assign o_result.current_channel  = CHAN_W'(r_out_slot);
    assign o_result.accepted         = r_out_acc;
    assign o_result.assigned_channel = CHAN_W'(r_out_asg);

    // a pin is only ever high for an attached channel
    a_levels_attached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_levels & ~r_attached) == '0)
        else $error("pin high on unattached channel");

    // attached flags always match the attach count
    a_count_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_attached) == int'(r_count))
        else $error("attach count and flags disagree");

    // an armed compare only exists on the final partial step
    a_armed_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |-> (r_ticks == '0))
        else $error("compare armed with ticks remaining");

    // timer stopped means no pulse and slot zero
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_levels == '0 && r_slot == '0 && r_count == '0))
        else $error("activity before first attach");

endmodule
